[src/mdst_pkg.sv]
// ----------------------------------------------------------------------------
// Mesh distance sharer tracker package
// Item codes and fixed field widths shared by the tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mdst_pkg;

   // Width of the node field of an input item.
   localparam int NODE_W = 4;

   // Number of distinct node codes the node field can carry.
   localparam int NODE_CODES = 1 << NODE_W;

   // Width of the kind field of an input item.
   localparam int KIND_W = 2;

   // Item kinds. The fourth code has no meaning and leaves the entry alone.
   typedef enum logic [KIND_W-1:0] {
      KIND_ADD    = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_CLEAR  = 2'd2
   } kind_type;

endpackage

`default_nettype wire

[src/mdst_entry.sv]
// ----------------------------------------------------------------------------
// Mesh distance sharer tracker entry state
// Holds the home node, its mesh coordinates and the radius, and works out
// the entry state that follows one item.
// ----------------------------------------------------------------------------
`default_nettype none

module mdst_entry #(
   parameter int NODES = 16,
   parameter int ROWS  = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                item_go,
   input  wire logic [mdst_pkg::KIND_W-1:0]         item_kind,
   input  wire logic [mdst_pkg::NODE_W-1:0]         item_node,
   output logic                                     used_in,
   output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] home_row_in,
   output logic [(((NODES / ROWS) > 1) ? $clog2(NODES / ROWS) : 1)-1:0] home_col_in,
   output logic [$clog2(ROWS + ((NODES / ROWS) == 0 ? 1 : (NODES / ROWS)) - 1)-1:0]
                                                    radius_in,
   output logic                                     mismatch
);

   localparam int COLS_RAW = NODES / ROWS;
   localparam int COLS     = (COLS_RAW == 0) ? 1 : COLS_RAW;
   localparam int MESH     = (ROWS * COLS < NODES) ? ROWS * COLS : NODES;
   localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W    = (COLS_RAW > 1) ? $clog2(COLS_RAW) : 1;
   localparam int RADIUS_W = $clog2(ROWS + COLS - 1);

   logic                used_ff;
   logic [mdst_pkg::NODE_W-1:0] home_node_ff;
   logic [mdst_pkg::NODE_W-1:0] home_node_in;
   logic [ROW_W-1:0]    home_row_ff;
   logic [COL_W-1:0]    home_col_ff;
   logic [RADIUS_W-1:0] radius_ff;

   // Row and column of every node code, fixed by the mesh shape.
   logic [ROW_W-1:0]    row_tab [mdst_pkg::NODE_CODES];
   logic [COL_W-1:0]    col_tab [mdst_pkg::NODE_CODES];

   for (genvar v = 0; v < mdst_pkg::NODE_CODES; v++) begin : g_tab
      assign row_tab[v] = ROW_W'(v / COLS);
      assign col_tab[v] = COL_W'(v % COLS);
   end

   // Distance of the named node from the current home.
   logic [ROW_W-1:0]    node_row;
   logic [COL_W-1:0]    node_col;
   logic [ROW_W-1:0]    row_diff;
   logic [COL_W-1:0]    col_diff;
   logic [RADIUS_W-1:0] node_dist;
   logic                node_in_mesh;

   always_comb begin
      node_row     = row_tab[item_node];
      node_col     = col_tab[item_node];
      row_diff     = (node_row > home_row_ff) ? node_row - home_row_ff
                                              : home_row_ff - node_row;
      col_diff     = (node_col > home_col_ff) ? node_col - home_col_ff
                                              : home_col_ff - node_col;
      node_dist    = RADIUS_W'(row_diff) + RADIUS_W'(col_diff);
      node_in_mesh = 32'(item_node) < MESH;
   end

   // Next entry state for the item in flight.
   always_comb begin
      used_in      = used_ff;
      home_node_in = home_node_ff;
      home_row_in  = home_row_ff;
      home_col_in  = home_col_ff;
      radius_in    = radius_ff;
      mismatch     = 1'b0;
      unique case (mdst_pkg::kind_type'(item_kind))
         mdst_pkg::KIND_ADD: begin
            if (node_in_mesh) begin
               if (!used_ff) begin
                  used_in      = 1'b1;
                  home_node_in = item_node;
                  home_row_in  = node_row;
                  home_col_in  = node_col;
                  radius_in    = '0;
               end else if (node_dist > radius_ff) begin
                  radius_in = node_dist;
               end
            end
         end
         mdst_pkg::KIND_REMOVE: begin
            if (used_ff && (radius_ff == '0)) begin
               if (item_node == home_node_ff) begin
                  used_in = 1'b0;
               end else begin
                  mismatch = 1'b1;
               end
            end
         end
         mdst_pkg::KIND_CLEAR: begin
            used_in   = 1'b0;
            radius_in = '0;
         end
         default: begin
         end
      endcase
   end

   // The entry takes its new state when the item moves to the result stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= 1'b0;
         home_node_ff <= '0;
         home_row_ff  <= '0;
         home_col_ff  <= '0;
         radius_ff    <= '0;
      end else if (item_go) begin
         used_ff      <= used_in;
         home_node_ff <= home_node_in;
         home_row_ff  <= home_row_in;
         home_col_ff  <= home_col_in;
         radius_ff    <= radius_in;
      end
   end

`ifndef NO_ASSERTIONS
   // The radius only grows while the entry stays in use.
   assert property (@(posedge clock) disable iff (reset)
      item_go && used_ff && used_in |=> radius_ff >= $past(radius_ff))
      else $error("radius shrank on a live entry");

   // A mismatch leaves the entry untouched.
   assert property (@(posedge clock) disable iff (reset)
      item_go && mismatch |=> used_ff && $stable(home_node_ff) && $stable(radius_ff))
      else $error("mismatched remove changed the entry");

   // The state holds while no item moves on.
   assert property (@(posedge clock) disable iff (reset)
      !item_go |=> $stable(used_ff) && $stable(radius_ff) && $stable(home_node_ff))
      else $error("entry changed without an item");
`endif

endmodule

`default_nettype wire

[src/mdst_mask.sv]
// ----------------------------------------------------------------------------
// Mesh distance sharer tracker mask
// Compares every mesh node's distance from the home against the radius.
// ----------------------------------------------------------------------------
`default_nettype none

module mdst_mask #(
   parameter int NODES = 16,
   parameter int ROWS  = 4
) (
   input  wire logic                                used,
   input  wire logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] home_row,
   input  wire logic [(((NODES / ROWS) > 1) ? $clog2(NODES / ROWS) : 1)-1:0] home_col,
   input  wire logic [$clog2(ROWS + ((NODES / ROWS) == 0 ? 1 : (NODES / ROWS)) - 1)-1:0]
                                                    radius,
   output logic [NODES-1:0]                         mask
);

   localparam int COLS_RAW = NODES / ROWS;
   localparam int COLS     = (COLS_RAW == 0) ? 1 : COLS_RAW;
   localparam int MESH     = (ROWS * COLS < NODES) ? ROWS * COLS : NODES;
   localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W    = (COLS_RAW > 1) ? $clog2(COLS_RAW) : 1;
   localparam int RADIUS_W = $clog2(ROWS + COLS - 1);

   // One distance compare per node; nodes past the mesh never share.
   for (genvar n = 0; n < NODES; n++) begin : g_node
      if (n < MESH) begin : g_in
         localparam logic [ROW_W-1:0] NODE_ROW = ROW_W'(n / COLS);
         localparam logic [COL_W-1:0] NODE_COL = COL_W'(n % COLS);
         logic [ROW_W-1:0]    row_diff;
         logic [COL_W-1:0]    col_diff;
         logic [RADIUS_W-1:0] hops;
         always_comb begin
            row_diff = (NODE_ROW > home_row) ? NODE_ROW - home_row : home_row - NODE_ROW;
            col_diff = (NODE_COL > home_col) ? NODE_COL - home_col : home_col - NODE_COL;
            hops     = RADIUS_W'(row_diff) + RADIUS_W'(col_diff);
            mask[n]  = used && (hops <= radius);
         end
      end else begin : g_out
         assign mask[n] = 1'b0;
      end
   end

endmodule

`default_nettype wire

[src/mesh_distance_sharer_tracker_top.sv]
// ----------------------------------------------------------------------------
// Mesh distance sharer tracker
// Coarse directory sharer entry for a 2D mesh: home node plus Manhattan
// radius, reported as a per-node sharer mask after every item.
// ----------------------------------------------------------------------------
//
//  channel | direction | ports
//  --------+-----------+----------------------------------------------------
//  req     | in        | req_valid, req_ready, req_kind, req_node
//  rsp     | out       | rsp_valid, rsp_ready, rsp_sharer_mask,
//          |           | rsp_is_broadcast, rsp_entry_valid, rsp_remove_mismatch
//
//  Each item passes through the input register and then the result register;
//  one item per cycle sustained while rsp_ready stays high.
//  The entry update and all per-node distance compares sit in the single
//  logic stage between those two registers.
//  Reset empties the entry and both registers.
//  A stalled result holds its register; the input register still takes one
//  more item, after which req_ready follows rsp_ready.
//
`default_nettype none

module mesh_distance_sharer_tracker_top #(
   parameter int NODES = 16,
   parameter int ROWS  = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [mdst_pkg::KIND_W-1:0]  req_kind,
   input  wire logic [mdst_pkg::NODE_W-1:0]  req_node,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [NODES-1:0]                  rsp_sharer_mask,
   output logic                              rsp_is_broadcast,
   output logic                              rsp_entry_valid,
   output logic                              rsp_remove_mismatch
);

   localparam int COLS_RAW = NODES / ROWS;
   localparam int COLS     = (COLS_RAW == 0) ? 1 : COLS_RAW;
   localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W    = (COLS_RAW > 1) ? $clog2(COLS_RAW) : 1;
   localparam int RADIUS_W = $clog2(ROWS + COLS - 1);

   // Input register.
   logic                        in_valid_ff;
   logic                        in_valid_in;
   logic [mdst_pkg::KIND_W-1:0] in_kind_ff;
   logic [mdst_pkg::NODE_W-1:0] in_node_ff;

   // Result register.
   logic                        out_valid_ff;
   logic                        out_valid_in;
   logic [NODES-1:0]            out_mask_ff;
   logic                        out_broadcast_ff;
   logic                        out_used_ff;
   logic                        out_mismatch_ff;

   // Next entry state and mask for the item in the input register.
   logic                        used_in;
   logic [ROW_W-1:0]            home_row_in;
   logic [COL_W-1:0]            home_col_in;
   logic [RADIUS_W-1:0]         radius_in;
   logic                        mismatch;
   logic [NODES-1:0]            mask;

   logic                        out_free;
   logic                        item_go;
   logic                        req_fire;

   // Flow control between the two registers.
   always_comb begin
      out_free     = !out_valid_ff || rsp_ready;
      item_go      = in_valid_ff && out_free;
      req_ready    = !in_valid_ff || out_free;
      req_fire     = req_valid && req_ready;
      in_valid_in  = req_fire || (in_valid_ff && !item_go);
      out_valid_in = item_go || (out_valid_ff && !rsp_ready);
   end

   mdst_entry #(
      .NODES (NODES),
      .ROWS  (ROWS)
   ) u_entry (
      .clock       (clock),
      .reset       (reset),
      .item_go     (item_go),
      .item_kind   (in_kind_ff),
      .item_node   (in_node_ff),
      .used_in     (used_in),
      .home_row_in (home_row_in),
      .home_col_in (home_col_in),
      .radius_in   (radius_in),
      .mismatch    (mismatch)
   );

   mdst_mask #(
      .NODES (NODES),
      .ROWS  (ROWS)
   ) u_mask (
      .used     (used_in),
      .home_row (home_row_in),
      .home_col (home_col_in),
      .radius   (radius_in),
      .mask     (mask)
   );

   // Valid flags of both registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload of the input register.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff <= req_kind;
         in_node_ff <= req_node;
      end
   end

   // Payload of the result register.
   always_ff @(posedge clock) begin
      if (item_go) begin
         out_mask_ff      <= mask;
         out_broadcast_ff <= &mask;
         out_used_ff      <= used_in;
         out_mismatch_ff  <= mismatch;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_sharer_mask     = out_mask_ff;
   assign rsp_is_broadcast    = out_broadcast_ff;
   assign rsp_entry_valid     = out_used_ff;
   assign rsp_remove_mismatch = out_mismatch_ff;

`ifndef NO_ASSERTIONS
   // An empty entry shares with nobody.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |-> rsp_sharer_mask == '0)
      else $error("empty entry reports sharers");

   // A live entry always covers at least its home node.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_valid |-> rsp_sharer_mask != '0)
      else $error("live entry reports no sharers");

   // A mismatch is only reported against a live entry.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_remove_mismatch |-> rsp_entry_valid)
      else $error("mismatch reported on an empty entry");

   // An item accepted into an empty input register is held there in the cycle after.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && !in_valid_ff |=> in_valid_ff)
      else $error("accepted item lost from the input register");
`endif

endmodule

`default_nettype wire
